// ----- rtl/ssx_pkg.sv -----
// shared types and constants for the salsa20 stream xor unit
`timescale 1ns / 1ps

package ssx_pkg;

	typedef logic [31:0] word_t;
	typedef logic [1:0]  step_t;
	typedef logic [3:0]  widx_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		CFG_KEY_LOW      = 2'd0,
		CFG_KEY_HIGH     = 2'd1,
		CFG_NONCE        = 2'd2,
		CFG_START_OFFSET = 2'd3
	} cfg_reg_t;

	// "expand 16-byte k"
	localparam word_t SIGMA0 = 32'h6170_7865;
	localparam word_t SIGMA1 = 32'h3120_646e;
	localparam word_t SIGMA2 = 32'h7962_2d36;
	localparam word_t SIGMA3 = 32'h6b20_6574;

	// column round and row round together, counted as half rounds
	localparam int HALF_ROUNDS = 20;
	localparam int HALF_W      = 5;

	localparam int ROT0 = 7;
	localparam int ROT1 = 9;
	localparam int ROT2 = 13;
	localparam int ROT3 = 18;

	// word places of the four column quarter rounds, in a, b, c, d order
	localparam widx_t QPOS [4][4] = '{
		'{4'd0,  4'd4,  4'd8,  4'd12},
		'{4'd5,  4'd9,  4'd13, 4'd1 },
		'{4'd10, 4'd14, 4'd2,  4'd6 },
		'{4'd15, 4'd3,  4'd7,  4'd11}
	};

	typedef struct packed {
		logic  accept;     // input word taken this cycle
		logic  init;       // load working state from the input block
		logic  round;      // one quarter-round step in all four lanes
		step_t step;       // which step of the quarter round
		logic  final_add;  // feed-forward add into the keystream block
		logic  emit;       // write the result word to the output register
	} ssx_cmd_t;

	typedef struct packed {
		logic need_block;  // a new keystream block is required for this word
		logic out_stall;   // output register holds a word not yet taken
	} ssx_stat_t;

endpackage

// ----- rtl/ssx_qr_step.sv -----
// one add-rotate-xor step of a salsa20 quarter round
`timescale 1ns / 1ps

module ssx_qr_step (
	input  ssx_pkg::step_t step,
	input  ssx_pkg::word_t a,
	input  ssx_pkg::word_t d,
	input  ssx_pkg::word_t t,
	output ssx_pkg::word_t y
);
	import ssx_pkg::*;

	word_t sum;
	word_t rot;

	assign sum = a + d;

	always_comb begin
		case (step)
			2'd0: rot = (sum << ROT0) | (sum >> (32 - ROT0));
			2'd1: rot = (sum << ROT1) | (sum >> (32 - ROT1));
			2'd2: rot = (sum << ROT2) | (sum >> (32 - ROT2));
			2'd3: rot = (sum << ROT3) | (sum >> (32 - ROT3));
			default: rot = sum;
		endcase
	end

	assign y = t ^ rot;

endmodule

// ----- rtl/ssx_datapath.sv -----
// datapath: config registers, counter, round state, keystream block and output register
`timescale 1ns / 1ps

module ssx_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  ssx_pkg::cfg_reg_t cfg_index,
	input  logic [63:0]      cfg_data,
	input  logic [7:0]       in_byte,
	input  logic             in_first,
	input  logic             in_last,
	input  ssx_pkg::ssx_cmd_t cmd,
	output ssx_pkg::ssx_stat_t stat,
	input  logic             m_tready,
	output logic             m_tvalid,
	output logic [7:0]       m_tdata,
	output logic             m_tlast
);
	import ssx_pkg::*;

	logic [63:0] key_low_q;
	logic [63:0] key_high_q;
	logic [63:0] nonce_q;
	logic [63:0] start_offset_q;
	logic [63:0] counter_q;
	logic [5:0]  pos_q;
	logic [7:0]  data_q;
	logic        last_q;
	logic        first_q;
	word_t       work_q [16];
	word_t       ks_q [16];
	logic        m_tvalid_q;
	logic [7:0]  m_tdata_q;
	logic        m_tlast_q;

	word_t in_blk [16];
	word_t work_nxt [16];
	word_t work_stp [16];
	word_t lane_a [4];
	word_t lane_d [4];
	word_t lane_t [4];
	word_t lane_y [4];
	widx_t lane_tgt [4];
	word_t ks_word;
	logic [7:0] ks_byte;

	// from config and counter; counter holds during a block, config only if user holds it
	always_comb begin
		in_blk[0]  = SIGMA0;
		in_blk[5]  = SIGMA1;
		in_blk[10] = SIGMA2;
		in_blk[15] = SIGMA3;
		in_blk[1]  = key_low_q[31:0];
		in_blk[2]  = key_low_q[63:32];
		in_blk[3]  = key_high_q[31:0];
		in_blk[4]  = key_high_q[63:32];
		in_blk[11] = key_low_q[31:0];
		in_blk[12] = key_low_q[63:32];
		in_blk[13] = key_high_q[31:0];
		in_blk[14] = key_high_q[63:32];
		in_blk[6]  = nonce_q[31:0];
		in_blk[7]  = nonce_q[63:32];
		in_blk[8]  = counter_q[31:0];
		in_blk[9]  = counter_q[63:32];
	end

	// step s of a quarter round updates word s+1 from words s and s+3
	always_comb begin
		for (int l = 0; l < 4; l++) begin
			case (cmd.step)
				2'd0: begin
					lane_a[l]   = work_q[QPOS[l][0]];
					lane_d[l]   = work_q[QPOS[l][3]];
					lane_t[l]   = work_q[QPOS[l][1]];
					lane_tgt[l] = QPOS[l][1];
				end
				2'd1: begin
					lane_a[l]   = work_q[QPOS[l][1]];
					lane_d[l]   = work_q[QPOS[l][0]];
					lane_t[l]   = work_q[QPOS[l][2]];
					lane_tgt[l] = QPOS[l][2];
				end
				2'd2: begin
					lane_a[l]   = work_q[QPOS[l][2]];
					lane_d[l]   = work_q[QPOS[l][1]];
					lane_t[l]   = work_q[QPOS[l][3]];
					lane_tgt[l] = QPOS[l][3];
				end
				default: begin
					lane_a[l]   = work_q[QPOS[l][3]];
					lane_d[l]   = work_q[QPOS[l][2]];
					lane_t[l]   = work_q[QPOS[l][0]];
					lane_tgt[l] = QPOS[l][0];
				end
			endcase
		end
	end

	for (genvar g = 0; g < 4; g++) begin : g_lane
		ssx_qr_step u_step (
			.step (cmd.step),
			.a    (lane_a[g]),
			.d    (lane_d[g]),
			.t    (lane_t[g]),
			.y    (lane_y[g])
		);
	end

	always_comb begin
		work_stp = work_q;
		for (int l = 0; l < 4; l++) begin
			work_stp[lane_tgt[l]] = lane_y[l];
		end
	end

	// a row round is a column round on the transposed state, so transpose
	// after every half round; twenty transposes leave the order unchanged
	always_comb begin
		if (cmd.step == 2'd3) begin
			for (int i = 0; i < 16; i++) begin
				work_nxt[i] = work_stp[((i % 4) * 4) + (i / 4)];
			end
		end else begin
			work_nxt = work_stp;
		end
	end

	assign ks_word = ks_q[pos_q[5:2]];
	assign ks_byte = ks_word[8 * pos_q[1:0] +: 8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q      <= '0;
			key_high_q     <= '0;
			nonce_q        <= '0;
			start_offset_q <= '0;
			counter_q      <= '0;
			pos_q          <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_LOW:      key_low_q      <= cfg_data;
					CFG_KEY_HIGH:     key_high_q     <= cfg_data;
					CFG_NONCE:        nonce_q        <= cfg_data;
					CFG_START_OFFSET: start_offset_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.accept && in_first) begin
				counter_q <= {32'd0, start_offset_q[37:6]};
				pos_q     <= start_offset_q[5:0];
			end else if (cmd.emit) begin
				pos_q <= pos_q + 6'd1;
				if (pos_q == 6'd63) begin
					counter_q <= counter_q + 64'd1;
				end
			end
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			data_q  <= in_byte;
			last_q  <= in_last;
			first_q <= in_first;
		end
		if (cmd.init) begin
			work_q <= in_blk;
		end else if (cmd.round) begin
			work_q <= work_nxt;
		end
		if (cmd.final_add) begin
			for (int i = 0; i < 16; i++) begin
				ks_q[i] <= work_q[i] + in_blk[i];
			end
		end
		if (cmd.emit) begin
			m_tdata_q <= data_q ^ ks_byte;
			m_tlast_q <= last_q;
		end
	end

	assign stat.need_block = first_q || (pos_q == 6'd0);
	assign stat.out_stall  = m_tvalid_q && !m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// ----- rtl/ssx_ctrl.sv -----
// controller: sequences accept, block generation and result output
`timescale 1ns / 1ps

module ssx_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  ssx_pkg::ssx_stat_t stat,
	output ssx_pkg::ssx_cmd_t  cmd
);
	import ssx_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} state_t;

	state_t            state_q;
	step_t             step_q;
	logic [HALF_W-1:0] half_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			half_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					step_q <= '0;
					half_q <= '0;
					state_q <= stat.need_block ? ST_ROUND : ST_EMIT;
				end
				ST_ROUND: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						half_q <= half_q + HALF_W'(1);
						if (half_q == HALF_W'(HALF_ROUNDS - 1)) begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_FINAL: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!stat.out_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready      = (state_q == ST_IDLE);
	assign cmd.accept    = s_tvalid && s_tready;
	assign cmd.init      = (state_q == ST_CHECK);
	assign cmd.round     = (state_q == ST_ROUND);
	assign cmd.step      = step_q;
	assign cmd.final_add = (state_q == ST_FINAL);
	assign cmd.emit      = (state_q == ST_EMIT) && !stat.out_stall;

endmodule

// ----- rtl/salsa20_stream_xor_unit.sv -----
// top level of the salsa20/20 stream xor unit
//
// Usage: write key_low, key_high, nonce and start_offset over the cfg channel
// (cfg_ready is always high) while no word is in flight. Message bytes enter on
// the s_ channel: tdata is the byte, tuser marks the first byte of a message
// (counter and byte position reload from start_offset), tlast marks the last
// byte and is passed to m_tlast. Each byte leaves on the m_ channel XORed with
// the keystream byte at the current position.
// One byte is worked on at a time. A byte that needs no new keystream block
// goes from acceptance through a check state to the emit state, which writes
// its result into the output register that drives m_tvalid. The first byte
// of a message and every byte at block position 0 first run the round unit:
// 4 quarter rounds in parallel, one add-rotate-xor step per cycle, for 20
// rounds, then a feed-forward add into the keystream block before the emit.
// Reset clears config, block counter and position and empties the output.
// When the receiver stalls, the result holds in the output register; the next
// byte is still accepted and processed, then waits until that register frees.
`timescale 1ns / 1ps

module salsa20_stream_xor_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  ssx_pkg::cfg_reg_t cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] data_byte
	input  logic              s_tuser,   // [0] first_of_message
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,   // [7:0] result_byte
	output logic              m_tlast
);
	import ssx_pkg::*;

	ssx_cmd_t  cmd;
	ssx_stat_t stat;

	assign cfg_ready = 1'b1;

	ssx_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ssx_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_byte   (s_tdata),
		.in_first  (s_tuser),
		.in_last   (s_tlast),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- rtl/ssx_checker.sv -----
// port-level checks for the salsa20 stream xor unit, bound to the top level
`timescale 1ns / 1ps

module ssx_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// one word in work at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while a word is in work");

	// a result only comes out of a word in work
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared with no word in work");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

endmodule

bind salsa20_stream_xor_unit ssx_checker u_ssx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.m_tlast   (m_tlast)
);

// ----- sim/ssx_keystream_checker.sv -----
// checker for the salsa20 stream xor unit: keystream prediction and result comparison
`timescale 1ns / 1ps

module ssx_keystream_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  ssx_pkg::cfg_reg_t cfg_index,
	input  logic [63:0]       cfg_data,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] data_byte
	input  logic              s_tuser,   // [0] first_of_message
	input  logic              s_tlast,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [7:0]        m_tdata,   // [7:0] result_byte
	input  logic              m_tlast,
	output int                mismatches,
	output int                outstanding
);
	import ssx_pkg::*;

	typedef logic [15:0][31:0] salsa_blk_t;

	typedef struct packed {
		logic [7:0] cipher;
		logic       last;
	} xor_word_t;

	// "expand 16-byte k"
	localparam logic [31:0] EXPAND0 = 32'h6170_7865;
	localparam logic [31:0] EXPAND1 = 32'h3120_646e;
	localparam logic [31:0] EXPAND2 = 32'h7962_2d36;
	localparam logic [31:0] EXPAND3 = 32'h6b20_6574;
	localparam int          DOUBLE_ROUNDS = 10;

	logic [63:0] key_lo;
	logic [63:0] key_hi;
	logic [63:0] nonce_val;
	logic [63:0] start_off;
	salsa_blk_t  keystream;
	logic [63:0] blk_count;
	logic [5:0]  blk_pos;
	xor_word_t   expected_words[$];
	int          fail_cnt;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic salsa_blk_t quarter(input salsa_blk_t w, input int a, input int b,
			input int c, input int d);
		w[b] = w[b] ^ rotl(w[a] + w[d], 7);
		w[c] = w[c] ^ rotl(w[b] + w[a], 9);
		w[d] = w[d] ^ rotl(w[c] + w[b], 13);
		w[a] = w[a] ^ rotl(w[d] + w[c], 18);
		return w;
	endfunction

	function automatic salsa_blk_t salsa_block(input logic [63:0] kl, input logic [63:0] kh,
			input logic [63:0] nn, input logic [63:0] ctr);
		salsa_blk_t seed_blk;
		salsa_blk_t work;
		int         i;
		seed_blk[0]  = EXPAND0;
		seed_blk[1]  = kl[31:0];
		seed_blk[2]  = kl[63:32];
		seed_blk[3]  = kh[31:0];
		seed_blk[4]  = kh[63:32];
		seed_blk[5]  = EXPAND1;
		seed_blk[6]  = nn[31:0];
		seed_blk[7]  = nn[63:32];
		seed_blk[8]  = ctr[31:0];
		seed_blk[9]  = ctr[63:32];
		seed_blk[10] = EXPAND2;
		// 128-bit key appears a second time
		seed_blk[11] = kl[31:0];
		seed_blk[12] = kl[63:32];
		seed_blk[13] = kh[31:0];
		seed_blk[14] = kh[63:32];
		seed_blk[15] = EXPAND3;
		work = seed_blk;
		for (i = 0; i < DOUBLE_ROUNDS; i++) begin
			work = quarter(work, 0, 4, 8, 12);
			work = quarter(work, 5, 9, 13, 1);
			work = quarter(work, 10, 14, 2, 6);
			work = quarter(work, 15, 3, 7, 11);
			work = quarter(work, 0, 1, 2, 3);
			work = quarter(work, 5, 6, 7, 4);
			work = quarter(work, 10, 11, 8, 9);
			work = quarter(work, 15, 12, 13, 14);
		end
		for (i = 0; i < 16; i++)
			seed_blk[i] = work[i] + seed_blk[i];
		return seed_blk;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		xor_word_t  want;
		logic [7:0] ks_byte;
		if (!arst_n) begin
			key_lo    = '0;
			key_hi    = '0;
			nonce_val = '0;
			start_off = '0;
			keystream = '0;
			blk_count = '0;
			blk_pos   = '0;
			expected_words.delete();
			fail_cnt  = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_KEY_LOW:      key_lo    = cfg_data;
					CFG_KEY_HIGH:     key_hi    = cfg_data;
					CFG_NONCE:        nonce_val = cfg_data;
					CFG_START_OFFSET: start_off = cfg_data;
					default: ;
				endcase
			end

			// results first, so a result can never match the word taken this same edge
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					$error("result_byte: no word expected, got %02h", m_tdata);
					fail_cnt++;
				end else begin
					want = expected_words.pop_front();
					if (m_tdata !== want.cipher) begin
						$error("result_byte: expected %02h, got %02h", want.cipher, m_tdata);
						fail_cnt++;
					end
					if (m_tlast !== want.last) begin
						$error("last_out: expected %0b, got %0b", want.last, m_tlast);
						fail_cnt++;
					end
				end
			end

			if (s_tvalid && s_tready) begin
				if (s_tuser) begin
					// high counter word restarts at zero
					blk_count = {32'd0, start_off[37:6]};
					blk_pos   = start_off[5:0];
				end
				if (s_tuser || blk_pos == 6'd0)
					keystream = salsa_block(key_lo, key_hi, nonce_val, blk_count);
				ks_byte = keystream[blk_pos[5:2]][8 * blk_pos[1:0] +: 8];
				want.cipher = s_tdata ^ ks_byte;
				want.last   = s_tlast;
				expected_words.push_back(want);
				blk_pos = blk_pos + 6'd1;
				if (blk_pos == 6'd0)
					blk_count = blk_count + 64'd1;
			end

			mismatches  <= fail_cnt;
			outstanding <= expected_words.size();
		end
	end

endmodule

// ----- sim/salsa20_stream_xor_unit_tb.sv -----
// testbench top for the salsa20 stream xor unit: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module salsa20_stream_xor_unit_tb;
	import ssx_pkg::*;

	localparam int ITEM_TARGET = 1700;
	localparam int IDLE_LIMIT  = 2000;
	localparam int HOLD_CYCLES = 160;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	cfg_reg_t    cfg_index = CFG_KEY_LOW;
	logic [63:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	int mismatches;
	int outstanding;
	int bytes_sent   = 0;
	int results_seen = 0;
	int idle_cycles  = 0;

	always #5 clk = ~clk;

	salsa20_stream_xor_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	ssx_keystream_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input logic [63:0] kl, input logic [63:0] kh,
			input logic [63:0] nn, input logic [63:0] off);
		write_reg(CFG_KEY_LOW, kl);
		write_reg(CFG_KEY_HIGH, kh);
		write_reg(CFG_NONCE, nn);
		write_reg(CFG_START_OFFSET, off);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
		int gap;
		// a stretch of back-to-back words
		gap = (bytes_sent >= 400 && bytes_sent < 600) ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= data;
		s_tuser  <= first;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	// stop offering and wait until every word has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic send_message(input int len);
		int   k;
		logic first;
		logic last;
		for (k = 0; k < len; k++) begin
			first = (k == 0);
			last  = (k == len - 1);
			// occasional broken framing
			if ($urandom_range(0, 19) == 0)
				first = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 19) == 0)
				last = 1'($urandom_range(0, 1));
			send_byte(8'($urandom_range(0, 255)), first, last);
		end
	endtask

	function automatic logic [63:0] pick_offset();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 2))
			0: ;
			1: r = r & 64'hfff;
			default: r[5:0] = 6'($urandom_range(56, 63));
		endcase
		return r;
	endfunction

	initial begin : stimulus
		int len;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// no settings written and no first mark: zero key, counter zero
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'ha5, 1'b0, 1'b1);
		settle();

		load_settings('1, '0, '1, '0);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'h3c, 1'b0, 1'b1);
		settle();

		// start on the last byte of a block, so the counter steps mid-message
		load_settings('0, '1, '0, 64'd63);
		send_byte(8'h81, 1'b1, 1'b0);
		send_byte(8'h7e, 1'b0, 1'b0);
		send_byte(8'hc3, 1'b0, 1'b1);
		settle();

		// counter low word all ones, carry into the high word
		load_settings({$urandom, $urandom}, {$urandom, $urandom}, '0, '1);
		send_byte(8'h12, 1'b1, 1'b0);
		send_byte(8'hed, 1'b0, 1'b0);
		send_byte(8'h99, 1'b0, 1'b1);
		settle();

		// one-byte message, then a restart inside a message
		send_byte(8'h5a, 1'b1, 1'b1);
		send_byte(8'h66, 1'b1, 1'b0);
		send_byte(8'h24, 1'b0, 1'b0);
		send_byte(8'hdb, 1'b1, 1'b1);
		settle();

		while (bytes_sent < ITEM_TARGET) begin
			load_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
				pick_offset());
			repeat ($urandom_range(3, 8)) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150)
					: $urandom_range(1, 16);
				send_message(len);
			end
			settle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("** salsa20_stream_xor_unit: PASSED **");
		else
			$display("** salsa20_stream_xor_unit: FAILED **");
		$finish;
	end

	initial begin : receiver
		int stall_len;
		wait (arst_n);
		@(posedge clk);
		forever begin
			// long hold-off so the unit fills up and stalls its input
			if (results_seen == 300 || results_seen == 1100) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall_len = (results_seen >= 800 && results_seen < 1000) ? 0
				: $urandom_range(0, 4);
			if (stall_len != 0) begin
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_seen++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else if (idle_cycles >= IDLE_LIMIT) begin
				$display("** salsa20_stream_xor_unit: FAILED **");
				$finish;
			end else
				idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
